@@ rtl/aes_pkg.sv @@
// package for the aes-128 block cipher: types, tables and byte helpers
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned RkDepth   = NumRounds + 1;
  localparam int unsigned RkAw      = $clog2(RkDepth);

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ROUND,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  // control from the sequencer to the round datapath
  typedef struct packed {
    logic load;
    logic byte_step;
    logic col_step;
    logic rnd_done;
    logic shift;
    logic decrypt;
  } rnd_ctrl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] k);
    logic [7:0] r;
    case (k)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/aes128_block_cipher_unit.sv @@
// aes-128 encrypt/decrypt unit, byte-serial rounds, apb key port, stream data
// A block is taken only while the unit is idle. Key expansion then writes one round key
// per cycle into the round key ram; the initial key add fetches its round key and adds it.
// Rounds 1 to 9 each fetch the key, shift the rows, pass the 16 state bytes through the
// single s-box byte lane, mix the four columns and add the key (decrypt adds the key
// before mixing); the last round skips the mix. The result is held on m_axis until
// taken; only then is a new block accepted. Keys sit at 0x0 (high) and 0x8 (low) and
// reset to zero; the user must change them only while no block is in flight (not enforced).
module aes128_block_cipher_unit
  import aes_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // block_high, block_low
  input  logic         s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // result_high, result_low
);

  ctrl_state_e       st_q, st_d;
  logic [63:0]       key_high_q, key_low_q;
  logic              dec_q;
  logic [3:0]        rnd_q, rnd_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [3:0]        kcnt_q, kcnt_d;
  logic [1:0]        ph_q, ph_d;
  logic [BlockW-1:0] blk_q;
  logic [BlockW-1:0] rk_gen, rk_rd, state;
  logic              rk_we, ks_start, ks_step;
  logic [RkAw-1:0]   raddr;
  rnd_ctrl_t         rc;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[3] == REG_KEY_LOW) ? key_low_q : key_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we && paddr[2:0] == 3'd0) begin
      if (paddr[3] == REG_KEY_HIGH) key_high_q <= pwdata;
      else key_low_q <= pwdata;
    end
  end

  aes_keyexp u_keyexp (
    .clk_i, .start_i(ks_start), .key_i({key_high_q, key_low_q}),
    .step_i(ks_step), .rnd_i(kcnt_d), .rk_o(rk_gen)
  );

  aes_ram #(.Width(BlockW), .Depth(RkDepth)) u_rk_ram (
    .clk_i, .we_i(rk_we), .waddr_i(kcnt_q), .wdata_i(rk_gen),
    .raddr_i(raddr), .rdata_o(rk_rd)
  );

  aes_round u_round (.clk_i, .ctrl_i(rc), .blk_i(blk_q), .rk_i(rk_rd), .state_o(state));

  // phase 0: fetch key, 1: row shift and sbox bytes, 2: mix columns, 3: add key
  always_comb begin
    st_d = st_q; rnd_d = rnd_q; cnt_d = cnt_q; kcnt_d = kcnt_q; ph_d = ph_q;
    ks_start = 1'b0; ks_step = 1'b0; rk_we = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          st_d = ST_EXPAND; kcnt_d = '0; ks_start = 1'b1;
        end
      end
      ST_EXPAND: begin
        rk_we = 1'b1;
        if (kcnt_q == 4'(NumRounds)) begin
          st_d = ST_ROUND; rnd_d = '0; ph_d = 2'd0;
        end else begin
          kcnt_d = kcnt_q + 4'd1; ks_step = 1'b1;
        end
      end
      ST_ROUND: begin
        case (ph_q)
          2'd0: begin
            if (rnd_q == '0) begin
              ph_d = 2'd3;
            end else begin
              ph_d = 2'd1; cnt_d = '0;
            end
          end
          2'd1: begin
            cnt_d = cnt_q + 5'd1;
            if (cnt_q == 5'd16) begin
              if (dec_q || rnd_q == 4'(NumRounds)) begin
                ph_d = 2'd3;
              end else begin
                ph_d = 2'd2; cnt_d = '0;
              end
            end
          end
          2'd2: begin
            cnt_d = cnt_q + 5'd1;
            if (cnt_q == 5'd3) begin
              if (dec_q) begin
                ph_d = 2'd0; rnd_d = rnd_q + 4'd1;
              end else begin
                ph_d = 2'd3;
              end
            end
          end
          default: begin
            if (rnd_q == 4'(NumRounds)) begin
              st_d = ST_OUT;
            end else if (rnd_q == '0 || !dec_q) begin
              ph_d = 2'd0; rnd_d = rnd_q + 4'd1;
            end else begin
              ph_d = 2'd2; cnt_d = '0;
            end
          end
        endcase
      end
      default: begin
        if (m_axis_tready) st_d = ST_IDLE;
      end
    endcase
  end

  // round key address: encrypt uses round rnd, decrypt uses NumRounds-rnd
  always_comb begin
    raddr = dec_q ? RkAw'(4'(NumRounds) - rnd_q) : RkAw'(rnd_q);
    rc = '0;
    rc.decrypt   = dec_q;
    rc.load      = st_q == ST_ROUND && ph_q == 2'd3 && rnd_q == '0;
    rc.shift     = st_q == ST_ROUND && ph_q == 2'd1 && cnt_q == 5'd0;
    rc.byte_step = st_q == ST_ROUND && ph_q == 2'd1 && cnt_q != 5'd0;
    rc.col_step  = st_q == ST_ROUND && ph_q == 2'd2;
    rc.rnd_done  = st_q == ST_ROUND && ph_q == 2'd3 && rnd_q != '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; rnd_q <= '0; cnt_q <= '0; kcnt_q <= '0; ph_q <= '0; dec_q <= 1'b0;
    end else begin
      st_q <= st_d; rnd_q <= rnd_d; cnt_q <= cnt_d; kcnt_q <= kcnt_d; ph_q <= ph_d;
      if (st_q == ST_IDLE && s_axis_tvalid) dec_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && s_axis_tvalid) blk_q <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  end

  assign s_axis_tready = st_q == ST_IDLE;
  assign m_axis_tvalid = st_q == ST_OUT;
  assign m_axis_tdata  = {state[63:0], state[127:64]};

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("both sides active");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_kcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_EXPAND |-> kcnt_q <= 4'(NumRounds)) else $error("key count overrun");

endmodule

@@ rtl/aes_ram.sv @@
// generic single-port write, registered read ram
module aes_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/aes_keyexp.sv @@
// key schedule: one round key per cycle while step_i is set, written to the round key ram
module aes_keyexp
  import aes_pkg::*;
(
  input  logic              clk_i,
  input  logic              start_i,
  input  logic [BlockW-1:0] key_i,
  input  logic              step_i,
  input  logic [3:0]        rnd_i,
  output logic [BlockW-1:0] rk_o
);

  logic [BlockW-1:0] rk_q, rk_d;
  logic [31:0]       g;
  logic [31:0]       w0, w1, w2, w3;

  always_comb begin
    g  = {Sbox[rk_q[23:16]] ^ rcon(rnd_i), Sbox[rk_q[15:8]], Sbox[rk_q[7:0]],
          Sbox[rk_q[31:24]]};
    w0 = rk_q[127:96] ^ g;
    w1 = rk_q[95:64] ^ w0;
    w2 = rk_q[63:32] ^ w1;
    w3 = rk_q[31:0] ^ w2;
    rk_d = rk_q;
    if (start_i) begin
      rk_d = key_i;
    end else if (step_i) begin
      rk_d = {w0, w1, w2, w3};
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q <= rk_d;
  end

  assign rk_o = rk_q;

endmodule

@@ rtl/aes_round.sv @@
// byte-serial round datapath: state rotates one byte per cycle through the s-box while byte_step is set
module aes_round
  import aes_pkg::*;
(
  input  logic              clk_i,
  input  rnd_ctrl_t         ctrl_i,
  input  logic [BlockW-1:0] blk_i,
  input  logic [BlockW-1:0] rk_i,
  output logic [BlockW-1:0] state_o
);

  logic [BlockW-1:0] st_q, st_d;
  logic [BlockW-1:0] sr, isr;
  logic [7:0]        sb;
  logic [31:0]       col, mc;
  logic [7:0]        a0, a1, a2, a3;
  logic [7:0]        x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;

  function automatic logic [7:0] by(input logic [BlockW-1:0] s, input int unsigned i);
    return s[BlockW-1-8*i -: 8];
  endfunction

  always_comb begin
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        sr[BlockW-1-8*(4*c+r) -: 8] = by(st_q, 4*((c+r)%4)+r);
        isr[BlockW-1-8*(4*((c+r)%4)+r) -: 8] = by(st_q, 4*c+r);
      end
    end
  end

  // mix one column per cycle at the head of the state while col_step is set
  always_comb begin
    col = st_q[BlockW-1 -: 32];
    a0 = col[31:24]; a1 = col[23:16]; a2 = col[15:8]; a3 = col[7:0];
    x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
    y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
    z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
    if (!ctrl_i.decrypt) begin
      mc = {x0 ^ x1 ^ a1 ^ a2 ^ a3, a0 ^ x1 ^ x2 ^ a2 ^ a3,
            a0 ^ a1 ^ x2 ^ x3 ^ a3, x0 ^ a0 ^ a1 ^ a2 ^ x3};
    end else begin
      mc = {z0^y0^x0 ^ z1^x1^a1 ^ z2^y2^a2 ^ z3^a3,
            z0^a0 ^ z1^y1^x1 ^ z2^x2^a2 ^ z3^y3^a3,
            z0^y0^a0 ^ z1^a1 ^ z2^y2^x2 ^ z3^x3^a3,
            z0^x0^a0 ^ z1^y1^a1 ^ z2^a2 ^ z3^y3^x3};
    end
  end

  assign sb = ctrl_i.decrypt ? InvSbox[st_q[BlockW-1 -: 8]] : Sbox[st_q[BlockW-1 -: 8]];

  // row shift goes ahead of the s-box pass since the two commute
  always_comb begin
    st_d = st_q;
    if (ctrl_i.load) begin
      st_d = blk_i ^ rk_i;
    end else if (ctrl_i.shift) begin
      st_d = ctrl_i.decrypt ? isr : sr;
    end else if (ctrl_i.byte_step) begin
      st_d = {st_q[BlockW-9:0], sb};
    end else if (ctrl_i.col_step) begin
      st_d = {st_q[BlockW-33:0], mc};
    end else if (ctrl_i.rnd_done) begin
      st_d = st_q ^ rk_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign state_o = st_q;

endmodule
